### design/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants
// step format, hit side codes and per-axis control flags
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int STEP_BITS = 24;
  localparam int STEP_FRAC = 8;
  localparam int SIDE_BITS = 3;

  localparam logic [SIDE_BITS-1:0] SIDE_NONE   = 3'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_LEFT   = 3'd1;
  localparam logic [SIDE_BITS-1:0] SIDE_RIGHT  = 3'd2;
  localparam logic [SIDE_BITS-1:0] SIDE_BOTTOM = 3'd3;
  localparam logic [SIDE_BITS-1:0] SIDE_TOP    = 3'd4;

  typedef struct packed {
    logic s_zero;
    logic s_neg;
    logic in_neg;
    logic out_neg;
  } axis_flags_t;

endpackage

### design/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front: item classifier
// picks entry and exit gaps per axis, splits them into magnitude and sign
// ----------------------------------------------------------------------------
module sac_front #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0]          mover_left,
  input  logic [COORD_BITS-1:0]          mover_right,
  input  logic [COORD_BITS-1:0]          mover_top,
  input  logic [COORD_BITS-1:0]          mover_bottom,
  input  logic [COORD_BITS-1:0]          target_left,
  input  logic [COORD_BITS-1:0]          target_right,
  input  logic [COORD_BITS-1:0]          target_top,
  input  logic [COORD_BITS-1:0]          target_bottom,
  input  logic [sac_pkg::STEP_BITS-1:0]  step_x,
  input  logic [sac_pkg::STEP_BITS-1:0]  step_y,
  output logic [COORD_BITS:0]            xin_mag,
  output logic [COORD_BITS:0]            xout_mag,
  output logic [COORD_BITS:0]            yin_mag,
  output logic [COORD_BITS:0]            yout_mag,
  output logic [sac_pkg::STEP_BITS-1:0]  sx_mag,
  output logic [sac_pkg::STEP_BITS-1:0]  sy_mag,
  output sac_pkg::axis_flags_t           flags_x,
  output sac_pkg::axis_flags_t           flags_y
);
  import sac_pkg::*;

  localparam int GW = COORD_BITS + 1;
  localparam int CB = COORD_BITS - 1;

  logic signed [GW-1:0] gap_lr, gap_rl, gap_bt, gap_tb;
  logic signed [GW-1:0] xin, xout, yin, yout;
  logic                 sx_pos, sy_pos, sx_zero, sy_zero;

  assign gap_lr = $signed({target_left[CB], target_left})
                - $signed({mover_right[CB], mover_right});
  assign gap_rl = $signed({target_right[CB], target_right})
                - $signed({mover_left[CB], mover_left});
  assign gap_bt = $signed({target_bottom[CB], target_bottom})
                - $signed({mover_top[CB], mover_top});
  assign gap_tb = $signed({target_top[CB], target_top})
                - $signed({mover_bottom[CB], mover_bottom});

  assign sx_zero = (step_x == '0);
  assign sy_zero = (step_y == '0);
  assign sx_pos  = !step_x[STEP_BITS-1] && !sx_zero;
  assign sy_pos  = !step_y[STEP_BITS-1] && !sy_zero;

  assign xin  = sx_pos ? gap_lr : gap_rl;
  assign xout = sx_pos ? gap_rl : gap_lr;
  assign yin  = sy_pos ? gap_bt : gap_tb;
  assign yout = sy_pos ? gap_tb : gap_bt;

  assign xin_mag  = xin[GW-1]  ? GW'(-xin)  : GW'(xin);
  assign xout_mag = xout[GW-1] ? GW'(-xout) : GW'(xout);
  assign yin_mag  = yin[GW-1]  ? GW'(-yin)  : GW'(yin);
  assign yout_mag = yout[GW-1] ? GW'(-yout) : GW'(yout);

  assign sx_mag = step_x[STEP_BITS-1] ? STEP_BITS'(-step_x) : step_x;
  assign sy_mag = step_y[STEP_BITS-1] ? STEP_BITS'(-step_y) : step_y;

  assign flags_x.s_zero  = sx_zero;
  assign flags_x.s_neg   = step_x[STEP_BITS-1];
  assign flags_x.in_neg  = xin[GW-1]  != step_x[STEP_BITS-1];
  assign flags_x.out_neg = xout[GW-1] != step_x[STEP_BITS-1];
  assign flags_y.s_zero  = sy_zero;
  assign flags_y.s_neg   = step_y[STEP_BITS-1];
  assign flags_y.in_neg  = yin[GW-1]  != step_y[STEP_BITS-1];
  assign flags_y.out_neg = yout[GW-1] != step_y[STEP_BITS-1];

endmodule

### design/sac_queue.sv
// ----------------------------------------------------------------------------
// sac_queue: two-entry item queue
// decouples the classifier from the divider pipeline
// ----------------------------------------------------------------------------
module sac_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [0:1];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/sac_div.sv
// ----------------------------------------------------------------------------
// sac_div: pipelined time divider
// gap * 2^(8+frac) / step, one quotient bit per stage, saturated at 2.0
// ----------------------------------------------------------------------------
module sac_div #(
  parameter int GAP_BITS  = 17,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [GAP_BITS-1:0]           gap_mag,
  input  logic [sac_pkg::STEP_BITS-1:0] step_mag,
  input  logic                          neg,
  output logic signed [FRAC_BITS+2:0]   quo
);
  import sac_pkg::*;

  localparam int AW = GAP_BITS + STEP_FRAC;
  localparam int RW = STEP_BITS + 1;
  localparam int CW = (AW > RW ? AW : RW) + 1;
  localparam int QW = FRAC_BITS + 2;
  localparam logic [QW-1:0] QMAX = {2'b10, {FRAC_BITS{1'b0}}};

  logic [STEP_BITS-1:0] rem_r  [0:FRAC_BITS];
  logic [STEP_BITS-1:0] step_r [0:FRAC_BITS];
  logic [QW-1:0]        q_r    [0:FRAC_BITS];
  logic                 sat_r  [0:FRAC_BITS];
  logic                 neg_r  [0:FRAC_BITS];

  logic [CW-1:0] a_ext, s1_ext, s2_ext, diff;
  logic          ge1, ge2;
  logic [1:0]    ip;
  logic [QW-1:0] mag;

  assign a_ext  = CW'(gap_mag) << STEP_FRAC;
  assign s1_ext = CW'(step_mag);
  assign s2_ext = s1_ext << 1;
  assign ge2    = a_ext >= s2_ext;
  assign ge1    = a_ext >= s1_ext;
  assign ip     = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
  assign diff   = a_ext - (ge2 ? s2_ext : (ge1 ? s1_ext : '0));

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= diff[STEP_BITS-1:0];
      step_r[0] <= step_mag;
      q_r[0]    <= QW'(ip);
      sat_r[0]  <= a_ext > s2_ext;
      neg_r[0]  <= neg;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
    logic [RW-1:0] r2, sub;
    logic          ge;
    assign r2  = {rem_r[k-1], 1'b0};
    assign ge  = r2 >= {1'b0, step_r[k-1]};
    assign sub = r2 - {1'b0, step_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? sub[STEP_BITS-1:0] : r2[STEP_BITS-1:0];
        step_r[k] <= step_r[k-1];
        q_r[k]    <= {q_r[k-1][QW-2:0], ge};
        sat_r[k]  <= sat_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end
    end
  end

  assign mag = sat_r[FRAC_BITS] ? QMAX : q_r[FRAC_BITS];
  assign quo = neg_r[FRAC_BITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### design/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back: divider pipeline and hit decision
// four time dividers in lockstep, then entry/exit compare and output register
// ----------------------------------------------------------------------------
module sac_back #(
  parameter int GAP_BITS  = 17,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [GAP_BITS-1:0]             xin_mag,
  input  logic [GAP_BITS-1:0]             xout_mag,
  input  logic [GAP_BITS-1:0]             yin_mag,
  input  logic [GAP_BITS-1:0]             yout_mag,
  input  logic [sac_pkg::STEP_BITS-1:0]   sx_mag,
  input  logic [sac_pkg::STEP_BITS-1:0]   sy_mag,
  input  sac_pkg::axis_flags_t            flags_x,
  input  sac_pkg::axis_flags_t            flags_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [FRAC_BITS:0]              out_time,
  output logic [sac_pkg::SIDE_BITS-1:0]   out_side,
  output logic                            out_hit
);
  import sac_pkg::*;

  localparam int TW = FRAC_BITS + 3;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] T_POS_INF = (TW'(1) << (FRAC_BITS + 1)) + TW'(1);
  localparam logic signed [TW-1:0] T_NEG_INF = -T_POS_INF;

  logic [FRAC_BITS:0]  vld_r, vld_nxt;
  axis_flags_t         fx_r [0:FRAC_BITS];
  axis_flags_t         fy_r [0:FRAC_BITS];
  logic                out_vld_r;
  logic [FRAC_BITS:0]  time_r;
  logic [SIDE_BITS-1:0] side_r;
  logic                hit_r;
  logic                en;

  logic signed [TW-1:0] q_xin, q_xout, q_yin, q_yout;
  logic signed [TW-1:0] xin, xout, yin, yout, entry, exitt;
  logic                 miss;
  logic [FRAC_BITS:0]   time_nxt;
  logic [SIDE_BITS-1:0] side_nxt;
  axis_flags_t          fx, fy;

  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  sac_div #(.GAP_BITS(GAP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_xin (
    .clk(clk), .en(en), .gap_mag(xin_mag), .step_mag(sx_mag),
    .neg(flags_x.in_neg), .quo(q_xin));
  sac_div #(.GAP_BITS(GAP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_xout (
    .clk(clk), .en(en), .gap_mag(xout_mag), .step_mag(sx_mag),
    .neg(flags_x.out_neg), .quo(q_xout));
  sac_div #(.GAP_BITS(GAP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_yin (
    .clk(clk), .en(en), .gap_mag(yin_mag), .step_mag(sy_mag),
    .neg(flags_y.in_neg), .quo(q_yin));
  sac_div #(.GAP_BITS(GAP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_yout (
    .clk(clk), .en(en), .gap_mag(yout_mag), .step_mag(sy_mag),
    .neg(flags_y.out_neg), .quo(q_yout));

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r[0] <= flags_x;
      fy_r[0] <= flags_y;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        fx_r[k] <= fx_r[k-1];
        fy_r[k] <= fy_r[k-1];
      end
    end
  end

  assign fx = fx_r[FRAC_BITS];
  assign fy = fy_r[FRAC_BITS];

  always_comb begin
    vld_nxt = {vld_r[FRAC_BITS-1:0], in_valid};
    xin     = fx.s_zero ? T_NEG_INF : q_xin;
    xout    = fx.s_zero ? T_POS_INF : q_xout;
    yin     = fy.s_zero ? T_NEG_INF : q_yin;
    yout    = fy.s_zero ? T_POS_INF : q_yout;
    entry   = (xin > yin) ? xin : yin;
    exitt   = (xout < yout) ? xout : yout;
    miss    = (entry > exitt) || (xin < 0 && yin < 0) || (xin > T_ONE) || (yin > T_ONE);
    if (miss) begin
      time_nxt = T_ONE[FRAC_BITS:0];
      side_nxt = SIDE_NONE;
    end else begin
      time_nxt = entry[FRAC_BITS:0];
      if (xin > yin) begin
        side_nxt = fx.s_neg ? SIDE_LEFT : SIDE_RIGHT;
      end else begin
        side_nxt = fy.s_neg ? SIDE_BOTTOM : SIDE_TOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      time_r <= time_nxt;
      side_r <= side_nxt;
      hit_r  <= !miss;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= vld_nxt;
      out_vld_r <= vld_r[FRAC_BITS];
    end
  end

  assign out_valid = out_vld_r;
  assign out_time  = time_r;
  assign out_side  = side_r;
  assign out_hit   = hit_r;

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !hit_r |-> side_r == SIDE_NONE && time_r == T_ONE[FRAC_BITS:0])
    else $error("miss result with side or time set");

  a_hit_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && hit_r |-> side_r != SIDE_NONE && time_r <= T_ONE[FRAC_BITS:0])
    else $error("hit result with no side or time past one");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(en) && !$past(vld_r[FRAC_BITS]) |-> !out_vld_r)
    else $error("result appeared from an empty stage");

endmodule

### design/swept_aabb_collision.sv
// ----------------------------------------------------------------------------
// swept_aabb_collision: swept vs fixed box, one pair per cycle when unstalled
//
// in_*  : one item holds both boxes and the mover's signed Q15.8 step.
// out_* : one result per item: impact time (Q1.TIME_FRAC_BITS), struck side
//         in tdata, hit flag in tuser. a miss reports time 1.0 and side none.
// a classifier forms the entry/exit gaps and writes a two-entry queue; the
// back end runs four dividers of TIME_FRAC_BITS+1 stages in lockstep and a
// decision stage that feeds the output register.
// an accepted item passes the queue, the divider stages and output register.
// throughput: one item per unstalled cycle, from the fully pipelined dividers.
// while a result waits on out_tready, the divider pipeline holds, the queue
// fills, and in_tready drops once both entries are taken; nothing is lost.
// reset (rst_n low, synchronous) empties the queue and the pipeline; no
// clearing pass is needed and items are taken the cycle after reset ends.
// ----------------------------------------------------------------------------
module swept_aabb_collision #(
  parameter int COORD_BITS     = 16,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // mover_left, mover_right, mover_top, mover_bottom, target_left,
  // target_right, target_top, target_bottom, step_x, step_y
  input  logic [8*COORD_BITS+2*sac_pkg::STEP_BITS-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // impact_time, hit_side, zero pad
  output logic [((TIME_FRAC_BITS+1+sac_pkg::SIDE_BITS+7)/8)*8-1:0] out_tdata,
  // hit
  output logic out_tuser
);
  import sac_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int GW  = COORD_BITS + 1;
  localparam int TB  = TIME_FRAC_BITS + 1;
  localparam int OW  = ((TB + SIDE_BITS + 7) / 8) * 8;
  localparam int QDW = 4 * GW + 2 * STEP_BITS + 2 * $bits(axis_flags_t);

  logic [GW-1:0]        f_xin, f_xout, f_yin, f_yout;
  logic [GW-1:0]        b_xin, b_xout, b_yin, b_yout;
  logic [STEP_BITS-1:0] f_sx, f_sy, b_sx, b_sy;
  axis_flags_t          f_fx, f_fy, b_fx, b_fy;
  logic [QDW-1:0]       q_in, q_out;
  logic                 q_valid, b_ready;
  logic [TB-1:0]        r_time;
  logic [SIDE_BITS-1:0] r_side;

  sac_front #(.COORD_BITS(COORD_BITS)) u_front (
    .mover_left    (in_tdata[0*C +: C]),
    .mover_right   (in_tdata[1*C +: C]),
    .mover_top     (in_tdata[2*C +: C]),
    .mover_bottom  (in_tdata[3*C +: C]),
    .target_left   (in_tdata[4*C +: C]),
    .target_right  (in_tdata[5*C +: C]),
    .target_top    (in_tdata[6*C +: C]),
    .target_bottom (in_tdata[7*C +: C]),
    .step_x        (in_tdata[8*C +: STEP_BITS]),
    .step_y        (in_tdata[8*C+STEP_BITS +: STEP_BITS]),
    .xin_mag       (f_xin),
    .xout_mag      (f_xout),
    .yin_mag       (f_yin),
    .yout_mag      (f_yout),
    .sx_mag        (f_sx),
    .sy_mag        (f_sy),
    .flags_x       (f_fx),
    .flags_y       (f_fy)
  );

  assign q_in = {f_fy, f_fx, f_sy, f_sx, f_yout, f_yin, f_xout, f_xin};

  sac_queue #(.WIDTH(QDW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  assign {b_fy, b_fx, b_sy, b_sx, b_yout, b_yin, b_xout, b_xin} = q_out;

  sac_back #(.GAP_BITS(GW), .FRAC_BITS(TIME_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (b_ready),
    .xin_mag   (b_xin),
    .xout_mag  (b_xout),
    .yin_mag   (b_yin),
    .yout_mag  (b_yout),
    .sx_mag    (b_sx),
    .sy_mag    (b_sy),
    .flags_x   (b_fx),
    .flags_y   (b_fy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_time  (r_time),
    .out_side  (r_side),
    .out_hit   (out_tuser)
  );

  assign out_tdata = OW'({r_side, r_time});

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: swept box collision check
// drives box pairs with random idling, predicts impact time, side and hit per
// item and compares each result in order; includes a long output hold-off.
// ----------------------------------------------------------------------------
class collision_board;
  logic [16:0] time_q[$];
  logic [2:0]  side_q[$];
  logic        hit_q[$];
  int          errors;

  function longint div_time(longint gap, longint stp);
    bit neg;
    longint g, s, q;
    neg = (gap < 0) != (stp < 0);
    g = gap < 0 ? -gap : gap;
    s = stp < 0 ? -stp : stp;
    if ((g <<< 8) > 2 * s) q = 131072;
    else q = (g <<< 24) / s;
    if (q > 131072) q = 131072;
    return neg ? -q : q;
  endfunction

  function void note_item(logic [175:0] d);
    longint ml, mr, mt, mb, tl, tr, tt, tbt, sx, sy;
    longint gxin, gxout, gyin, gyout, xin, xout, yin, yout, entry, exitt;
    logic [16:0] tm;
    logic [2:0] sd;
    logic h;
    ml = $signed(d[15:0]); mr = $signed(d[31:16]);
    mt = $signed(d[47:32]); mb = $signed(d[63:48]);
    tl = $signed(d[79:64]); tr = $signed(d[95:80]);
    tt = $signed(d[111:96]); tbt = $signed(d[127:112]);
    sx = $signed(d[151:128]); sy = $signed(d[175:152]);
    if (sx > 0) begin gxin = tl - mr; gxout = tr - ml; end
    else begin gxin = tr - ml; gxout = tl - mr; end
    if (sy > 0) begin gyin = tbt - mt; gyout = tt - mb; end
    else begin gyin = tt - mb; gyout = tbt - mt; end
    if (sx == 0) begin xin = -131073; xout = 131073; end
    else begin xin = div_time(gxin, sx); xout = div_time(gxout, sx); end
    if (sy == 0) begin yin = -131073; yout = 131073; end
    else begin yin = div_time(gyin, sy); yout = div_time(gyout, sy); end
    entry = xin > yin ? xin : yin;
    exitt = xout < yout ? xout : yout;
    tm = 17'h10000; sd = sac_pkg::SIDE_NONE; h = 1'b0;
    if (!(entry > exitt || (xin < 0 && yin < 0) || xin > 65536 || yin > 65536)) begin
      h = 1'b1;
      tm = entry[16:0];
      if (xin > yin) sd = sx < 0 ? sac_pkg::SIDE_LEFT : sac_pkg::SIDE_RIGHT;
      else sd = sy < 0 ? sac_pkg::SIDE_BOTTOM : sac_pkg::SIDE_TOP;
    end
    time_q.push_back(tm); side_q.push_back(sd); hit_q.push_back(h);
  endfunction

  function void check_result(logic [16:0] tm, logic [2:0] sd, logic h);
    logic [16:0] et;
    logic [2:0] es;
    logic eh;
    if (time_q.size() == 0) begin
      $error("unexpected result time=%0d side=%0d hit=%0d", tm, sd, h);
      errors++;
      return;
    end
    et = time_q.pop_front(); es = side_q.pop_front(); eh = hit_q.pop_front();
    if (tm !== et) begin $error("impact_time exp %0d got %0d", et, tm); errors++; end
    if (sd !== es) begin $error("hit_side exp %0d got %0d", es, sd); errors++; end
    if (h !== eh) begin $error("hit exp %0d got %0d", eh, h); errors++; end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [175:0] in_tdata;
  logic [23:0] out_tdata;
  collision_board board;
  bit idle_off, hold_req, sending_done;
  int quiet = 0;
  int rx_idle;

  swept_aabb_collision u_dut (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'(32'h8000 ^ $urandom_range(0, 3));
      default: return 16'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'($urandom());
      2: return 24'(32'h800000 ^ $urandom_range(0, 1));
      default: return 24'($urandom_range(0, 20000) - 10000);
    endcase
  endfunction

  task automatic send_item(logic [175:0] d);
    int gap;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(d);
    @(negedge clk);
  endtask

  function automatic logic [175:0] pack_item(logic [15:0] ml, mr, mt, mb, tl, tr, tt, tbt,
                                             logic [23:0] sx, sy);
    return {sy, sx, tbt, tt, tr, tl, mb, mt, mr, ml};
  endfunction

  function automatic logic [175:0] near_item();
    logic [15:0] ml, mt, tl, tbt;
    ml = 16'($urandom_range(0, 200) - 100); mt = 16'($urandom_range(0, 200) - 100);
    tl = 16'($urandom_range(0, 200) - 100); tbt = 16'($urandom_range(0, 200) - 100);
    return pack_item(ml, 16'(ml + $urandom_range(1, 20)), mt,
                     16'(mt - $urandom_range(1, 20)),
                     tl, 16'(tl + $urandom_range(1, 20)),
                     16'(tbt + $urandom_range(1, 20)), tbt,
                     ($urandom_range(0, 8) == 0) ? 24'd0 : 24'($urandom_range(0, 60000) - 30000),
                     ($urandom_range(0, 8) == 0) ? 24'd0 : 24'($urandom_range(0, 60000) - 30000));
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
      rx_idle <= 0;
    end else if (hold_req) out_tready <= 0;
    else if (idle_off) out_tready <= 1;
    else if (rx_idle > 0) begin
      out_tready <= 0;
      rx_idle <= rx_idle - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 0;
      rx_idle <= $urandom_range(0, 10);
    end else out_tready <= 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[16:0], out_tdata[19:17], out_tuser);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    hold_req = 0;
    wait (sending_done == 0);
    repeat (60) @(posedge clk);
    hold_req = 1;
    repeat (150) @(posedge clk);
    hold_req = 0;
  end

  initial begin
    board = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    // directed: hits on each side, statics, extremes
    send_item(pack_item(0, 10, 10, 0, 20, 30, 10, 0, 24'd5120, 24'd0));
    send_item(pack_item(20, 30, 10, 0, 0, 10, 10, 0, -24'sd5120, 24'd0));
    send_item(pack_item(0, 10, 10, 0, 0, 10, 30, 20, 24'd0, 24'd5120));
    send_item(pack_item(0, 10, 30, 20, 0, 10, 10, 0, 24'd0, -24'sd5120));
    send_item(pack_item(0, 10, 10, 0, 20, 30, 30, 20, 24'd5120, 24'd5120));
    send_item(pack_item(0, 10, 10, 0, 100, 110, 10, 0, 24'd256, 24'd0));
    send_item(pack_item(0, 10, 10, 0, 0, 10, 10, 0, 24'd0, 24'd0));
    send_item(pack_item(0, 10, 10, 0, 20, 30, 10, 0, -24'sd5120, 24'd256));
    send_item(pack_item(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                        16'h8000, 16'h7fff, 24'h7fffff, 24'h800000));
    send_item(pack_item(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h7fff, 16'h8000, 24'h800000, 24'h7fffff));
    send_item(pack_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'hffff, 24'hffffff, 24'hffffff));
    send_item(pack_item(0, 10, 10, 0, 10, 20, 10, 0, 24'd2560, 24'd1));
    for (int i = 0; i < 500; i++) begin
      if (i >= 420) idle_off = 1;
      if ($urandom_range(0, 3) != 0) send_item(near_item());
      else send_item(pack_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_step(), rand_step()));
    end
    in_tvalid <= 0;
    sending_done = 1;
    while (board.time_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

### filelist.f
design/sac_pkg.sv
design/sac_front.sv
design/sac_queue.sv
design/sac_div.sv
design/sac_back.sv
design/swept_aabb_collision.sv
tb/testbench.sv
